[rtl/lttb_pkg.sv]
package lttb_pkg;

	localparam int MaxPoints  = 4096;
	localparam int MaxTarget  = 1024;
	localparam int SampleBits = 24;
	localparam int CfgBits    = 11;
	localparam int PosBits    = 12;

	localparam logic ReqLoad = 1'b0;
	localparam logic ReqRead = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEL,
		S_BDIV,
		S_ADV1,
		S_ADV2,
		S_BUCKET,
		S_LAST,
		S_SUM,
		S_CDIV,
		S_RDA,
		S_RDAW,
		S_SCAN,
		S_NEXT,
		S_RD_IDX,
		S_RD_PT,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RS_SCAN,
		RS_A,
		RS_LAST,
		RS_OUT
	} rsel_t;

	typedef enum logic {
		MODE_SUM,
		MODE_AREA
	} mode_t;

	typedef struct packed {
		logic  load;
		logic  sel_init;
		logic  bdiv_start;
		logic  bnd_init;
		logic  bnd_adv;
		logic  pick_bs;
		logic  scan_start;
		mode_t scan_mode;
		logic  scan_step;
		logic  cdiv_start;
		logic  cent_mem;
		logic  cent_div;
		logic  a_cap;
		logic  pick_best;
		logic  bucket_next;
		logic  sel_finish;
		rsel_t rsel;
		logic  out_load;
		logic  out_empty;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic done;
		logic pass_cond;
		logic skip;
		logic has_next;
		logic last_bucket;
		logic issue_done;
		logic pipe_busy;
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

[rtl/lttb_if.sv]
interface lttb_req_if #(
	parameter int SAMPLE_BITS = lttb_pkg::SampleBits
);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [SAMPLE_BITS-1:0] sample_x;
	logic signed [SAMPLE_BITS-1:0] sample_y;
	logic                          sample_valid;

	modport source (output valid, req_type, sample_x, sample_y, sample_valid, input ready);
	modport sink (input valid, req_type, sample_x, sample_y, sample_valid, output ready);
endinterface

interface lttb_rsp_if #(
	parameter int SAMPLE_BITS = lttb_pkg::SampleBits
);
	logic                            valid;
	logic                            ready;
	logic signed [SAMPLE_BITS-1:0]   point_x;
	logic signed [SAMPLE_BITS-1:0]   point_y;
	logic [lttb_pkg::PosBits-1:0]    point_position;
	logic                            point_last;
	logic                            series_empty;

	modport source (output valid, point_x, point_y, point_position, point_last, series_empty,
		input ready);
	modport sink (input valid, point_x, point_y, point_position, point_last, series_empty,
		output ready);
endinterface

interface lttb_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [lttb_pkg::CfgBits-1:0] target_points;

	modport source (output valid, target_points, input ready);
	modport sink (input valid, target_points, output ready);
endinterface

[rtl/lttb_div.sv]
module lttb_div #(
	parameter int W = 37
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	localparam int CNW = $clog2(W + 1);

	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic [W-1:0]   quo_q;
	logic [W-1:0]   rem_q;
	logic [W-1:0]   den_q;
	logic [W:0]     trial;
	logic           ge;

	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? W'(trial - {1'b0, den_q}) : W'(trial);
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

[rtl/lttb_ctrl.sv]
module lttb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               req_type,
	input  lttb_pkg::status_t  st,
	output logic               in_ready,
	output lttb_pkg::cmd_t     cmd
);
	lttb_pkg::state_t state_q, state_nxt;
	logic             empty_q, empty_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lttb_pkg::S_IDLE;
			empty_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			empty_q <= empty_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		empty_nxt = empty_q;
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.rsel  = lttb_pkg::RS_OUT;
		cmd.scan_mode = lttb_pkg::MODE_SUM;
		case (state_q)
			lttb_pkg::S_IDLE: begin
				if (empty_q) begin
					if (st.out_free) begin
						cmd.out_empty = 1'b1;
						empty_nxt     = 1'b0;
					end
				end else begin
					in_ready = 1'b1;
					if (in_valid) begin
						if (req_type == lttb_pkg::ReqLoad)
							cmd.load = 1'b1;
						else if (st.empty)
							empty_nxt = 1'b1;
						else if (st.done)
							state_nxt = lttb_pkg::S_RD_IDX;
						else
							state_nxt = lttb_pkg::S_SEL;
					end
				end
			end
			lttb_pkg::S_SEL: begin
				cmd.sel_init = 1'b1;
				if (st.pass_cond) begin
					state_nxt = lttb_pkg::S_RD_IDX;
				end else begin
					cmd.bdiv_start = 1'b1;
					state_nxt      = lttb_pkg::S_BDIV;
				end
			end
			lttb_pkg::S_BDIV: begin
				if (!st.div_busy) begin
					cmd.bnd_init = 1'b1;
					state_nxt    = lttb_pkg::S_ADV1;
				end
			end
			lttb_pkg::S_ADV1: begin
				cmd.bnd_adv = 1'b1;
				state_nxt   = lttb_pkg::S_ADV2;
			end
			lttb_pkg::S_ADV2: begin
				cmd.bnd_adv = 1'b1;
				state_nxt   = lttb_pkg::S_BUCKET;
			end
			lttb_pkg::S_BUCKET: begin
				if (st.skip) begin
					cmd.pick_bs = 1'b1;
					state_nxt   = lttb_pkg::S_NEXT;
				end else if (st.has_next) begin
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = lttb_pkg::MODE_SUM;
					state_nxt      = lttb_pkg::S_SUM;
				end else begin
					cmd.rsel  = lttb_pkg::RS_LAST;
					state_nxt = lttb_pkg::S_LAST;
				end
			end
			lttb_pkg::S_LAST: begin
				cmd.rsel     = lttb_pkg::RS_LAST;
				cmd.cent_mem = 1'b1;
				state_nxt    = lttb_pkg::S_RDA;
			end
			lttb_pkg::S_SUM: begin
				cmd.rsel      = lttb_pkg::RS_SCAN;
				cmd.scan_mode = lttb_pkg::MODE_SUM;
				if (!st.issue_done) begin
					cmd.scan_step = 1'b1;
				end else if (!st.pipe_busy) begin
					cmd.cdiv_start = 1'b1;
					state_nxt      = lttb_pkg::S_CDIV;
				end
			end
			lttb_pkg::S_CDIV: begin
				if (!st.div_busy) begin
					cmd.cent_div = 1'b1;
					state_nxt    = lttb_pkg::S_RDA;
				end
			end
			lttb_pkg::S_RDA: begin
				cmd.rsel  = lttb_pkg::RS_A;
				state_nxt = lttb_pkg::S_RDAW;
			end
			lttb_pkg::S_RDAW: begin
				cmd.rsel       = lttb_pkg::RS_A;
				cmd.a_cap      = 1'b1;
				cmd.scan_start = 1'b1;
				cmd.scan_mode  = lttb_pkg::MODE_AREA;
				state_nxt      = lttb_pkg::S_SCAN;
			end
			lttb_pkg::S_SCAN: begin
				cmd.rsel      = lttb_pkg::RS_SCAN;
				cmd.scan_mode = lttb_pkg::MODE_AREA;
				if (!st.issue_done) begin
					cmd.scan_step = 1'b1;
				end else if (!st.pipe_busy) begin
					cmd.pick_best = 1'b1;
					state_nxt     = lttb_pkg::S_NEXT;
				end
			end
			lttb_pkg::S_NEXT: begin
				if (st.last_bucket) begin
					cmd.sel_finish = 1'b1;
					state_nxt      = lttb_pkg::S_RD_IDX;
				end else begin
					cmd.bucket_next = 1'b1;
					state_nxt       = lttb_pkg::S_BUCKET;
				end
			end
			lttb_pkg::S_RD_IDX: begin
				state_nxt = lttb_pkg::S_RD_PT;
			end
			lttb_pkg::S_RD_PT: begin
				state_nxt = lttb_pkg::S_EMIT;
			end
			lttb_pkg::S_EMIT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = lttb_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = lttb_pkg::S_IDLE;
			end
		endcase
	end
endmodule

[rtl/lttb_dp.sv]
module lttb_dp #(
	parameter int MAX_POINTS  = lttb_pkg::MaxPoints,
	parameter int MAX_TARGET  = lttb_pkg::MaxTarget,
	parameter int SAMPLE_BITS = lttb_pkg::SampleBits
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lttb_pkg::cmd_t                   cmd,
	output lttb_pkg::status_t                st,
	input  logic signed [SAMPLE_BITS-1:0]    sample_x,
	input  logic signed [SAMPLE_BITS-1:0]    sample_y,
	input  logic                             sample_valid,
	input  logic                             cfg_valid,
	input  logic [lttb_pkg::CfgBits-1:0]     cfg_target,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [SAMPLE_BITS-1:0]    point_x,
	output logic signed [SAMPLE_BITS-1:0]    point_y,
	output logic [lttb_pkg::PosBits-1:0]     point_position,
	output logic                             point_last,
	output logic                             series_empty
);
	localparam int SW   = SAMPLE_BITS;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int IW   = $clog2(MAX_POINTS);
	localparam int TW   = $clog2(MAX_TARGET);
	localparam int TCW  = $clog2(MAX_TARGET + 1);
	localparam int BW   = CW + 1;
	localparam int SUMW = SW + CW;
	localparam int AW   = 2 * SW + 4;
	localparam int GW0  = (CW > TCW) ? CW : TCW;
	localparam int GW   = (GW0 > lttb_pkg::CfgBits) ? GW0 : lttb_pkg::CfgBits;

	// sample and selection stores
	logic signed [SW-1:0] x_mem [MAX_POINTS];
	logic signed [SW-1:0] y_mem [MAX_POINTS];
	logic [IW-1:0]        ch_mem [MAX_TARGET];
	logic signed [SW-1:0] rdx_q, rdy_q;
	logic [IW-1:0]        ch_rd_q;
	logic [IW-1:0]        raddr;

	logic [lttb_pkg::CfgBits-1:0] target_q;
	logic [CW-1:0]  count_q, total_q, rp_q;
	logic           done_q, pass_q;
	logic [GW-1:0]  thr_q, tg, nn, thr_eff;
	logic [TCW-1:0] i_q;
	logic [IW-1:0]  a_q;

	// bucket bounds
	logic [CW-1:0] qs_q, rs_q, d_w;
	logic [BW-1:0] acc_q, b0_q, b1_q, b2_q, acc_new, nm1, bs, be, nbe;
	logic [CW-1:0] accr_q, accr_new;
	logic [CW:0]   rsum;
	logic          carry;

	// scan pipeline
	logic [IW-1:0]          k_q, e_q, k_s1, k_s2, k_s3, k_s4;
	lttb_pkg::mode_t        mode_q;
	logic                   v_s1, v_s2, v_s3, v_s4;
	logic signed [SW:0]     dx_s2, dy_s2;
	logic signed [2*SW+2:0] p1_s3, p2_s3;
	logic signed [AW-1:0]   diff;
	logic [AW-1:0]          area_s4, best_q;
	logic [IW-1:0]          best_k_q;
	logic                   first_q;

	// centroid
	logic signed [SUMW-1:0] sx_q, sy_q;
	logic [CW-1:0]          cnt_q;
	logic signed [SW:0]     cx_q, cy_q;
	logic signed [SW-1:0]   ax_q, ay_q;
	logic signed [SW+1:0]   ex_q, ey_q;
	logic [SUMW-1:0]        sx_mag, sy_mag, qx, rx, qy, ry, dvd_x, dvs_x, cxf, cyf;
	logic                   busy_x, busy_y, start_x, start_y;

	logic          ch_we;
	logic [TW-1:0] ch_wa;
	logic [IW-1:0] ch_wd;
	logic          out_last;

	always_comb begin
		tg      = GW'(target_q);
		nn      = GW'(count_q);
		thr_eff = (tg > GW'(MAX_TARGET)) ? GW'(MAX_TARGET) : tg;
		d_w     = CW'(thr_q - GW'(2));
		nm1     = BW'(count_q - 1'b1);
		bs      = (b0_q > nm1) ? nm1 : b0_q;
		be      = (b1_q > nm1) ? nm1 : b1_q;
		nbe     = (b2_q > nm1) ? nm1 : b2_q;
		rsum    = {1'b0, accr_q} + {1'b0, rs_q};
		carry   = rsum >= {1'b0, d_w};
		accr_new = carry ? CW'(rsum - {1'b0, d_w}) : CW'(rsum);
		acc_new = acc_q + BW'(qs_q) + BW'(carry);
		out_last = (BW'(rp_q) + 1'b1) == BW'(total_q);
	end

	always_comb begin
		st.empty       = count_q == '0;
		st.done        = done_q;
		st.pass_cond   = (tg <= GW'(2)) || (tg >= nn);
		st.skip        = bs >= be;
		st.has_next    = b1_q < nbe;
		st.last_bucket = ((GW+1)'(i_q) + (GW+1)'(3)) >= (GW+1)'(thr_q);
		st.issue_done  = k_q == e_q;
		st.pipe_busy   = v_s1 | v_s2 | v_s3 | v_s4;
		st.div_busy    = busy_x | busy_y;
		st.out_free    = !out_valid || out_ready;
	end

	always_comb begin
		case (cmd.rsel)
			lttb_pkg::RS_SCAN: raddr = k_q;
			lttb_pkg::RS_A:    raddr = a_q;
			lttb_pkg::RS_LAST: raddr = IW'(count_q - 1'b1);
			lttb_pkg::RS_OUT:  raddr = pass_q ? IW'(rp_q) : ch_rd_q;
			default:           raddr = k_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !done_q && sample_valid && (count_q < CW'(MAX_POINTS))) begin
			x_mem[IW'(count_q)] <= sample_x;
			y_mem[IW'(count_q)] <= sample_y;
		end
		rdx_q <= x_mem[raddr];
		rdy_q <= y_mem[raddr];
	end

	always_comb begin
		ch_we = 1'b1;
		ch_wa = TW'(i_q + 1'b1);
		ch_wd = best_k_q;
		if (cmd.sel_init) begin
			ch_wa = '0;
			ch_wd = '0;
		end else if (cmd.pick_bs) begin
			ch_wd = IW'(bs);
		end else if (cmd.sel_finish) begin
			ch_wa = TW'(thr_q - GW'(1));
			ch_wd = IW'(count_q - 1'b1);
		end else if (!cmd.pick_best) begin
			ch_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ch_we)
			ch_mem[ch_wa] <= ch_wd;
		ch_rd_q <= ch_mem[TW'(rp_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			count_q  <= '0;
			total_q  <= '0;
			rp_q     <= '0;
			done_q   <= 1'b0;
			pass_q   <= 1'b0;
			out_valid <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (cfg_valid)
				target_q <= cfg_target;
			if (cmd.load && !done_q && sample_valid && (count_q < CW'(MAX_POINTS)))
				count_q <= count_q + 1'b1;
			if (cmd.sel_init) begin
				rp_q <= '0;
				if (st.pass_cond) begin
					pass_q  <= 1'b1;
					done_q  <= 1'b1;
					total_q <= count_q;
				end else begin
					pass_q  <= 1'b0;
					total_q <= CW'(thr_eff);
				end
			end
			if (cmd.sel_finish) begin
				done_q <= 1'b1;
				rp_q   <= '0;
			end
			if (cmd.out_load || cmd.out_empty)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			if (cmd.out_load) begin
				if (out_last) begin
					count_q <= '0;
					rp_q    <= '0;
					done_q  <= 1'b0;
					pass_q  <= 1'b0;
					total_q <= '0;
				end else begin
					rp_q <= rp_q + 1'b1;
				end
			end
			v_s1 <= cmd.scan_step;
			v_s2 <= v_s1 && (mode_q == lttb_pkg::MODE_AREA);
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_empty) begin
			point_x        <= '0;
			point_y        <= '0;
			point_position <= '0;
			point_last     <= 1'b1;
			series_empty   <= 1'b1;
		end else if (cmd.out_load) begin
			point_x        <= rdx_q;
			point_y        <= rdy_q;
			point_position <= lttb_pkg::PosBits'(rp_q);
			point_last     <= out_last;
			series_empty   <= 1'b0;
		end
	end

	// bounds and bucket walk
	always_ff @(posedge clk) begin
		if (cmd.sel_init) begin
			thr_q <= thr_eff;
			i_q   <= '0;
			a_q   <= '0;
		end
		if (cmd.bnd_init) begin
			qs_q   <= CW'(qx);
			rs_q   <= CW'(rx);
			acc_q  <= '0;
			accr_q <= '0;
			b2_q   <= BW'(1);
		end
		if (cmd.bnd_adv || cmd.bucket_next) begin
			acc_q  <= acc_new;
			accr_q <= accr_new;
			b0_q   <= b1_q;
			b1_q   <= b2_q;
			b2_q   <= acc_new + 1'b1;
		end
		if (cmd.bucket_next)
			i_q <= i_q + 1'b1;
		if (cmd.pick_bs)
			a_q <= IW'(bs);
		if (cmd.pick_best)
			a_q <= best_k_q;
	end

	// scan, centroid sums and triangle areas
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			mode_q  <= cmd.scan_mode;
			first_q <= 1'b1;
			sx_q    <= '0;
			sy_q    <= '0;
			if (cmd.scan_mode == lttb_pkg::MODE_SUM) begin
				k_q   <= IW'(b1_q);
				e_q   <= IW'(nbe);
				cnt_q <= CW'(nbe - b1_q);
			end else begin
				k_q <= IW'(bs);
				e_q <= IW'(be);
			end
		end else if (cmd.scan_step) begin
			k_q <= k_q + 1'b1;
		end
		k_s1 <= k_q;
		if (v_s1 && (mode_q == lttb_pkg::MODE_SUM)) begin
			sx_q <= sx_q + SUMW'(rdx_q);
			sy_q <= sy_q + SUMW'(rdy_q);
		end
		dx_s2 <= (SW+1)'(rdx_q) - (SW+1)'(ax_q);
		dy_s2 <= (SW+1)'(rdy_q) - (SW+1)'(ay_q);
		k_s2  <= k_s1;
		p1_s3 <= dx_s2 * ex_q;
		p2_s3 <= dy_s2 * ey_q;
		k_s3  <= k_s2;
		area_s4 <= diff[AW-1] ? AW'(-diff) : AW'(diff);
		k_s4    <= k_s3;
		if (v_s4 && (first_q || (area_s4 > best_q))) begin
			best_q   <= area_s4;
			best_k_q <= k_s4;
			first_q  <= 1'b0;
		end
		if (cmd.cent_mem) begin
			cx_q <= (SW+1)'(rdx_q);
			cy_q <= (SW+1)'(rdy_q);
		end
		if (cmd.cent_div) begin
			cx_q <= cxf[SW:0];
			cy_q <= cyf[SW:0];
		end
		if (cmd.a_cap) begin
			ax_q <= rdx_q;
			ay_q <= rdy_q;
			ex_q <= (SW+2)'(cy_q) - (SW+2)'(rdy_q);
			ey_q <= (SW+2)'(cx_q) - (SW+2)'(rdx_q);
		end
	end

	always_comb begin
		diff   = AW'(p1_s3) - AW'(p2_s3);
		sx_mag = sx_q[SUMW-1] ? SUMW'(-sx_q) : SUMW'(sx_q);
		sy_mag = sy_q[SUMW-1] ? SUMW'(-sy_q) : SUMW'(sy_q);
		cxf    = sx_q[SUMW-1] ? SUMW'(-(qx + SUMW'(rx != '0))) : qx;
		cyf    = sy_q[SUMW-1] ? SUMW'(-(qy + SUMW'(ry != '0))) : qy;
		dvd_x  = cmd.bdiv_start ? SUMW'(count_q - CW'(2)) : sx_mag;
		dvs_x  = cmd.bdiv_start ? SUMW'(thr_eff - GW'(2)) : SUMW'(cnt_q);
		start_x = cmd.bdiv_start | cmd.cdiv_start;
		start_y = cmd.cdiv_start;
	end

	lttb_div #(.W(SUMW)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_x),
		.dividend (dvd_x),
		.divisor  (dvs_x),
		.busy     (busy_x),
		.quo      (qx),
		.rem      (rx)
	);

	lttb_div #(.W(SUMW)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_y),
		.dividend (sy_mag),
		.divisor  (SUMW'(cnt_q)),
		.busy     (busy_y),
		.quo      (qy),
		.rem      (ry)
	);

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("stored count beyond store depth");

	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load || cmd.out_empty) |-> (!out_valid || out_ready))
		else $error("result overwrites an undelivered beat");

	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rp_q < total_q))
		else $error("read position past output count");

	a_sel_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !pass_q) |-> (BW'(total_q) <= BW'(MAX_TARGET) && total_q < count_q))
		else $error("selected output count out of range");
endmodule

[rtl/lttb_downsampler_core.sv]
// Loads are accepted back to back while idle, one beat per cycle; no result.
// First read of a series runs the selection, using the bit-serial divider once for the
// bounds and once per averaged centroid (the final point stands in for the last centroid).
// Later reads each do a chosen-index read, then a sample read; empty reads flag series_empty.
// Reset clears counts, flags and the target register; the sample and index stores are not
// cleared and hold nothing valid until loaded.
module lttb_downsampler_core #(
	parameter int MAX_POINTS  = lttb_pkg::MaxPoints,
	parameter int MAX_TARGET  = lttb_pkg::MaxTarget,
	parameter int SAMPLE_BITS = lttb_pkg::SampleBits
) (
	input  logic       clk,
	input  logic       arst_n,
	lttb_req_if.sink   req,
	lttb_rsp_if.source rsp,
	lttb_cfg_if.sink   cfg
);
	lttb_pkg::cmd_t    cmd;
	lttb_pkg::status_t st;
	logic              in_ready;

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	lttb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.req_type (req.req_type),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	lttb_dp #(
		.MAX_POINTS  (MAX_POINTS),
		.MAX_TARGET  (MAX_TARGET),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.sample_x       (req.sample_x),
		.sample_y       (req.sample_y),
		.sample_valid   (req.sample_valid),
		.cfg_valid      (cfg.valid),
		.cfg_target     (cfg.target_points),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.point_x        (rsp.point_x),
		.point_y        (rsp.point_y),
		.point_position (rsp.point_position),
		.point_last     (rsp.point_last),
		.series_empty   (rsp.series_empty)
	);
endmodule
